// ===== src/dhfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dhfp_pkg
// shared types and constants for the message header field parser
// ----------------------------------------------------------------------------
package dhfp_pkg;

  localparam int STR_MAX    = 64;
  localparam int CNT_W      = $clog2(STR_MAX);
  localparam int NRES       = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [2:0] K_CHAR       = 3'd0;
  localparam logic [2:0] K_STR_END    = 3'd1;
  localparam logic [2:0] K_SUMMARY    = 3'd2;
  localparam logic [2:0] K_COMPLETE   = 3'd3;
  localparam logic [2:0] K_ERROR      = 3'd4;
  localparam logic [2:0] K_INCOMPLETE = 3'd5;

  localparam logic [1:0] E_ENDIAN  = 2'd1;
  localparam logic [1:0] E_OVERRUN = 2'd2;
  localparam logic [1:0] E_SIG     = 2'd3;

  localparam logic [1:0] F_DEST  = 2'd0;
  localparam logic [1:0] F_MEMB  = 2'd1;
  localparam logic [1:0] F_IFACE = 2'd2;

  localparam logic [7:0] CODE_IFACE = 8'd2;
  localparam logic [7:0] CODE_MEMB  = 8'd3;
  localparam logic [7:0] CODE_REPLY = 8'd5;
  localparam logic [7:0] CODE_DEST  = 8'd6;

  localparam logic [7:0] CH_LITTLE = 8'h6c;
  localparam logic [7:0] CH_BIG    = 8'h42;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_O      = 8'h6f;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_I      = 8'h69;

  typedef enum logic [3:0] {
    PH_FIXED, PH_PAD8, PH_CODE, PH_SIGLEN, PH_SIGFIRST, PH_SIGREST, PH_PAD4,
    PH_WORD, PH_STR, PH_GLEN, PH_GBYTES, PH_BODY, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  field_id;
    logic [5:0]  char_index;
    logic [7:0]  char_value;
    logic [7:0]  msg_type;
    logic [7:0]  msg_flags;
    logic [31:0] msg_serial;
    logic [31:0] reply_to_serial;
    logic [32:0] body_offset;
    logic [33:0] total_length;
    logic        big_endian;
    logic [1:0]  error_code;
  } res_t;

  typedef struct packed {
    logic            push;
    logic [1:0]      n;
    res_t [NRES-1:0] r;
  } push_t;

endpackage

// ===== src/dbus_header_field_parser.sv =====
// ----------------------------------------------------------------------------
// dbus_header_field_parser
// results pass the input register then queue; out one per cycle unless stalled
// throughput: one byte per cycle; a byte stalls while the result queue has
// fewer than three free slots, so up to three results per byte never drop
// reset: synchronous active low, clears parser state and empties the queue
// ----------------------------------------------------------------------------
module dbus_header_field_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dhfp_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dhfp_pkg::res_t     out_item
);
  import dhfp_pkg::*;

  logic     item_v_r;
  in_item_t item_r;
  logic     space_ok, take;
  push_t    push;

  assign take     = item_v_r && space_ok;
  assign in_stall = item_v_r && !space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (!in_stall) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) item_r <= in_item;
  end

  dhfp_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item_r),
    .push  (push)
  );

  dhfp_rfifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/dhfp_step.sv =====
// ----------------------------------------------------------------------------
// dhfp_step
// parser state and per-byte step logic, up to three results per item
// ----------------------------------------------------------------------------
module dhfp_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  dhfp_pkg::in_item_t  item,
  output dhfp_pkg::push_t     push
);
  import dhfp_pkg::*;

  logic [33:0]      off_r, off_nxt;
  phase_t           ph_r, ph_nxt;
  logic             big_r, big_nxt;
  logic [31:0]      ws_r, ws_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic [31:0]      serial_r, serial_nxt;
  logic [31:0]      blen_r, blen_nxt;
  logic [32:0]      hdr_r, hdr_nxt;
  logic [31:0]      reply_r, reply_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [7:0]       sig_r, sig_nxt;
  logic [33:0]      seg_r, seg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             halt_r, halt_nxt;

  always_comb begin
    logic [34:0] o, q, nx, p, lim;
    logic [32:0] he, bo;
    logic [33:0] tot;
    logic [31:0] wsn;
    logic [7:0]  b;
    logic [1:0]  n, fid;
    logic        fd, sd, cc, fx15, trk;
    res_t [NRES-1:0] r;

    b    = item.data_byte;
    n    = '0;
    r    = '0;
    fd   = 1'b0;
    sd   = 1'b0;
    cc   = 1'b0;
    fx15 = 1'b0;
    o    = '0;
    q    = '0;
    nx   = '0;
    p    = '0;
    lim  = '0;
    he   = '0;
    bo   = '0;
    tot  = '0;
    wsn  = '0;
    fid  = F_DEST;
    trk  = 1'b0;

    if (item.restart) begin
      off_nxt = '0; ph_nxt = PH_FIXED; big_nxt = 1'b0; ws_nxt = '0;
      type_nxt = '0; flags_nxt = '0; serial_nxt = '0; blen_nxt = '0;
      hdr_nxt = 33'd16; reply_nxt = '0; code_nxt = '0; sig_nxt = '0;
      seg_nxt = '0; cnt_nxt = '0; halt_nxt = 1'b0;
    end else begin
      off_nxt = off_r; ph_nxt = ph_r; big_nxt = big_r; ws_nxt = ws_r;
      type_nxt = type_r; flags_nxt = flags_r; serial_nxt = serial_r;
      blen_nxt = blen_r; hdr_nxt = hdr_r; reply_nxt = reply_r;
      code_nxt = code_r; sig_nxt = sig_r; seg_nxt = seg_r;
      cnt_nxt = cnt_r; halt_nxt = halt_r;
    end

    if (!halt_nxt) begin
      if (item.end_of_data) begin
        if (ph_nxt != PH_DONE) begin
          r[n].kind = K_INCOMPLETE;
          n = n + 2'd1;
        end
      end else if (ph_nxt != PH_DONE) begin
        o   = 35'(off_nxt);
        q   = o + 35'd1;
        wsn = big_nxt ? {ws_nxt[23:0], b} : {b, ws_nxt[31:8]};
        he  = hdr_nxt;
        case (code_nxt)
          CODE_DEST:  begin fid = F_DEST;  trk = 1'b1; end
          CODE_MEMB:  begin fid = F_MEMB;  trk = 1'b1; end
          CODE_IFACE: begin fid = F_IFACE; trk = 1'b1; end
          default:    begin fid = F_DEST;  trk = 1'b0; end
        endcase
        case (ph_nxt)
          PH_FIXED: begin
            ws_nxt = wsn;
            if (off_nxt == 34'd0) begin
              if (b == CH_LITTLE) big_nxt = 1'b0;
              else if (b == CH_BIG) big_nxt = 1'b1;
              else begin
                r[n].kind = K_ERROR; r[n].error_code = E_ENDIAN;
                n = n + 2'd1; halt_nxt = 1'b1;
              end
            end else if (off_nxt == 34'd1) type_nxt = b;
            else if (off_nxt == 34'd2) flags_nxt = b;
            else if (off_nxt == 34'd7) blen_nxt = wsn;
            else if (off_nxt == 34'd11) serial_nxt = wsn;
            else if (off_nxt == 34'd15) begin
              hdr_nxt = 33'd16 + 33'(wsn);
              if (wsn == 32'd0) begin
                fd = 1'b1; fx15 = 1'b1;
              end else ph_nxt = PH_CODE;
            end
          end
          PH_PAD8: if (q == 35'(seg_nxt)) ph_nxt = PH_CODE;
          PH_CODE: begin
            code_nxt = b;
            if (q >= 35'(he)) begin
              r[n].kind = K_ERROR; r[n].error_code = E_OVERRUN;
              n = n + 2'd1; halt_nxt = 1'b1;
            end else ph_nxt = PH_SIGLEN;
          end
          PH_SIGLEN, PH_GLEN: begin
            lim = q + 35'(b) + 35'd1;
            if (lim > 35'(he)) begin
              r[n].kind = K_ERROR; r[n].error_code = E_OVERRUN;
              n = n + 2'd1; halt_nxt = 1'b1;
            end else begin
              seg_nxt = lim[33:0];
              ph_nxt  = (ph_nxt == PH_SIGLEN) ? PH_SIGFIRST : PH_GBYTES;
            end
          end
          PH_SIGFIRST: begin
            if (q == 35'(seg_nxt)) begin
              sig_nxt = '0; sd = 1'b1;
            end else begin
              sig_nxt = b; ph_nxt = PH_SIGREST;
            end
          end
          PH_SIGREST: if (q == 35'(seg_nxt)) sd = 1'b1;
          PH_PAD4: if (q == 35'(seg_nxt)) ph_nxt = PH_WORD;
          PH_WORD: begin
            ws_nxt = wsn;
            if (o[1:0] == 2'd3) begin
              if (sig_nxt == CH_U || sig_nxt == CH_I) begin
                if (code_nxt == CODE_REPLY) reply_nxt = wsn;
                fd = 1'b1;
              end else begin
                lim = q + 35'(wsn) + 35'd1;
                if (lim > 35'(he)) begin
                  r[n].kind = K_ERROR; r[n].error_code = E_OVERRUN;
                  n = n + 2'd1; halt_nxt = 1'b1;
                end else begin
                  seg_nxt = lim[33:0]; cnt_nxt = '0; ph_nxt = PH_STR;
                end
              end
            end
          end
          PH_STR: begin
            if (q == 35'(seg_nxt)) begin
              if (trk) begin
                r[n].kind = K_STR_END; r[n].field_id = fid;
                r[n].char_index = 6'(cnt_nxt);
                n = n + 2'd1;
              end
              fd = 1'b1;
            end else if (trk && (32'(cnt_nxt) < 32'(STR_MAX - 1))) begin
              r[n].kind = K_CHAR; r[n].field_id = fid;
              r[n].char_index = 6'(cnt_nxt); r[n].char_value = b;
              n = n + 2'd1;
              cnt_nxt = cnt_nxt + 1'b1;
            end
          end
          PH_GBYTES: if (q == 35'(seg_nxt)) fd = 1'b1;
          PH_BODY: cc = 1'b1;
          default: ph_nxt = PH_DONE;
        endcase

        if (sd) begin
          if (sig_nxt == CH_S || sig_nxt == CH_O || sig_nxt == CH_U || sig_nxt == CH_I) begin
            p = (q + 35'd3) & ~35'd3;
            if (p + 35'd4 > 35'(he)) begin
              r[n].kind = K_ERROR; r[n].error_code = E_OVERRUN;
              n = n + 2'd1; halt_nxt = 1'b1;
            end else if (p == q) ph_nxt = PH_WORD;
            else begin
              seg_nxt = p[33:0]; ph_nxt = PH_PAD4;
            end
          end else if (sig_nxt == CH_G) begin
            if (q >= 35'(he)) begin
              r[n].kind = K_ERROR; r[n].error_code = E_OVERRUN;
              n = n + 2'd1; halt_nxt = 1'b1;
            end else ph_nxt = PH_GLEN;
          end else begin
            r[n].kind = K_ERROR; r[n].error_code = E_SIG;
            n = n + 2'd1; halt_nxt = 1'b1;
          end
        end

        bo  = fx15 ? 33'd16 : ((hdr_nxt + 33'd7) & ~33'd7);
        tot = 34'(bo) + 34'(blen_nxt);

        if (fd) begin
          nx = (q + 35'd7) & ~35'd7;
          if (nx >= 35'(bo)) begin
            r[n].kind = K_SUMMARY;
            r[n].msg_type = type_nxt; r[n].msg_flags = flags_nxt;
            r[n].msg_serial = serial_nxt; r[n].reply_to_serial = reply_nxt;
            r[n].body_offset = bo; r[n].total_length = tot;
            r[n].big_endian = big_nxt;
            n = n + 2'd1;
            ph_nxt = PH_BODY;
            cc = 1'b1;
          end else if (nx == q) ph_nxt = PH_CODE;
          else begin
            seg_nxt = nx[33:0]; ph_nxt = PH_PAD8;
          end
        end

        if (cc && (q == 35'(tot))) begin
          r[n].kind = K_COMPLETE;
          r[n].msg_type = type_nxt; r[n].msg_flags = flags_nxt;
          r[n].msg_serial = serial_nxt; r[n].reply_to_serial = reply_nxt;
          r[n].body_offset = bo; r[n].total_length = tot;
          r[n].big_endian = big_nxt;
          n = n + 2'd1;
          ph_nxt = PH_DONE;
        end

        off_nxt = q[33:0];
      end
    end

    push.push = take;
    push.n    = n;
    push.r    = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0; ph_r <= PH_FIXED; big_r <= 1'b0; ws_r <= '0;
      type_r <= '0; flags_r <= '0; serial_r <= '0; blen_r <= '0;
      hdr_r <= 33'd16; reply_r <= '0; code_r <= '0; sig_r <= '0;
      seg_r <= '0; cnt_r <= '0; halt_r <= 1'b0;
    end else if (take) begin
      off_r <= off_nxt; ph_r <= ph_nxt; big_r <= big_nxt; ws_r <= ws_nxt;
      type_r <= type_nxt; flags_r <= flags_nxt; serial_r <= serial_nxt;
      blen_r <= blen_nxt; hdr_r <= hdr_nxt; reply_r <= reply_nxt;
      code_r <= code_nxt; sig_r <= sig_nxt; seg_r <= seg_nxt;
      cnt_r <= cnt_nxt; halt_r <= halt_nxt;
    end
  end

endmodule

// ===== src/dhfp_rfifo.sv =====
// ----------------------------------------------------------------------------
// dhfp_rfifo
// result queue, up to three writes and one read per cycle, reads held by stall
// ----------------------------------------------------------------------------
module dhfp_rfifo (
  input  logic            clk,
  input  logic            rst_n,
  input  dhfp_pkg::push_t push,
  output logic            space_ok,
  output logic            out_valid,
  input  logic            out_stall,
  output dhfp_pkg::res_t  out_item
);
  import dhfp_pkg::*;

  res_t [FIFO_DEPTH-1:0] mem_r;
  logic [FIFO_AW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [FIFO_AW:0]      cnt_r, cnt_nxt;
  logic                  pop;
  logic [1:0]            nw;

  assign nw        = push.push ? push.n : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rptr_r];
  assign pop       = out_valid && !out_stall;
  assign space_ok  = (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - NRES));
  assign wptr_nxt  = wptr_r + FIFO_AW'(nw);
  assign rptr_nxt  = rptr_r + FIFO_AW'(pop);
  assign cnt_nxt   = cnt_r + (FIFO_AW+1)'(nw) - (FIFO_AW+1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NRES; i++) begin
      if (i < int'(nw)) mem_r[wptr_r + FIFO_AW'(i)] <= push.r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== src/dhfp_checker.sv =====
// ----------------------------------------------------------------------------
// dhfp_checker
// port-level checks on the header field parser
// ----------------------------------------------------------------------------
module dhfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dhfp_pkg::in_item_t in_item,
  input logic               out_valid,
  input logic               out_stall,
  input dhfp_pkg::res_t     out_item
);
  import dhfp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("output active after reset");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.kind <= K_INCOMPLETE)
    else $error("bad result kind");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == K_ERROR |-> out_item.error_code != 2'd0)
    else $error("error result without code");

endmodule

bind dbus_header_field_parser dhfp_checker u_chk (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the message header field parser against a byte-level predictor;
// directed messages over every signature, a cut string, errors and restarts
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dhfp_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_item_t in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  res_t     out_item;

  dbus_header_field_parser u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [33:0] p_off;
  phase_t      p_ph;
  logic        p_big;
  logic [31:0] p_word;
  logic [7:0]  p_type, p_flags;
  logic [31:0] p_serial, p_blen, p_reply;
  logic [32:0] p_hend;
  logic [7:0]  p_code, p_sig;
  logic [33:0] p_seg;
  int          p_cnt;
  logic        p_halt;

  in_item_t pending_bytes[$];
  res_t     expected_results[$];
  int       errors = 0;
  int       n_checked = 0;
  int       n_sent = 0;
  bit       in_acc = 1'b0;

  function automatic logic [33:0] up8(logic [33:0] v);
    return (v + 34'd7) & ~34'd7;
  endfunction

  function automatic logic [33:0] up4(logic [33:0] v);
    return (v + 34'd3) & ~34'd3;
  endfunction

  function automatic logic [33:0] body_start();
    return up8({1'b0, p_hend});
  endfunction

  function automatic logic [33:0] msg_end();
    return body_start() + {2'b0, p_blen};
  endfunction

  task automatic push_kind(logic [2:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    if (k == K_SUMMARY || k == K_COMPLETE) begin
      r.msg_type = p_type;
      r.msg_flags = p_flags;
      r.msg_serial = p_serial;
      r.reply_to_serial = p_reply;
      r.body_offset = 33'(body_start());
      r.total_length = msg_end();
      r.big_endian = p_big;
    end
    expected_results.push_back(r);
  endtask

  task automatic raise_error(logic [1:0] code);
    res_t r;
    r = '0;
    r.kind = K_ERROR;
    r.error_code = code;
    expected_results.push_back(r);
    p_halt = 1'b1;
  endtask

  task automatic parser_reset();
    p_off = '0; p_ph = PH_FIXED; p_big = 0; p_word = '0; p_type = '0;
    p_flags = '0; p_serial = '0; p_blen = '0; p_hend = 33'd16; p_reply = '0;
    p_code = '0; p_sig = '0; p_seg = '0; p_cnt = 0; p_halt = 0;
  endtask

  task automatic check_done(logic [33:0] o);
    if (o + 34'd1 == msg_end()) begin
      push_kind(K_COMPLETE);
      p_ph = PH_DONE;
    end
  endtask

  task automatic field_done(logic [33:0] o);
    logic [33:0] q, nx;
    q = o + 34'd1;
    nx = up8(q);
    if (nx >= {1'b0, p_hend}) begin
      push_kind(K_SUMMARY);
      p_ph = PH_BODY;
      check_done(o);
    end else if (nx == q) p_ph = PH_CODE;
    else begin
      p_seg = nx;
      p_ph = PH_PAD8;
    end
  endtask

  task automatic sig_done(logic [33:0] o);
    logic [33:0] q, p;
    q = o + 34'd1;
    if (p_sig == CH_S || p_sig == CH_O || p_sig == CH_U || p_sig == CH_I) begin
      p = up4(q);
      if (p + 34'd4 > {1'b0, p_hend}) raise_error(E_OVERRUN);
      else if (p == q) p_ph = PH_WORD;
      else begin
        p_seg = p;
        p_ph = PH_PAD4;
      end
    end else if (p_sig == CH_G) begin
      if (q >= {1'b0, p_hend}) raise_error(E_OVERRUN);
      else p_ph = PH_GLEN;
    end else raise_error(E_SIG);
  endtask

  task automatic shift_in(logic [7:0] b);
    if (p_big) p_word = {p_word[23:0], b};
    else p_word = {b, p_word[31:8]};
  endtask

  task automatic predict_byte(in_item_t it);
    logic [33:0] o;
    logic [7:0]  b;
    int          id;
    res_t        r;
    b = it.data_byte;
    o = p_off;
    if (it.restart) parser_reset();
    o = p_off;
    if (p_halt) return;
    if (it.end_of_data) begin
      if (p_ph != PH_DONE) push_kind(K_INCOMPLETE);
      return;
    end
    if (p_ph == PH_DONE) return;
    case (p_ph)
      PH_FIXED: begin
        shift_in(b);
        if (o == 0) begin
          if (b == CH_LITTLE) p_big = 0;
          else if (b == CH_BIG) p_big = 1;
          else raise_error(E_ENDIAN);
        end else if (o == 1) p_type = b;
        else if (o == 2) p_flags = b;
        else if (o == 7) p_blen = p_word;
        else if (o == 11) p_serial = p_word;
        else if (o == 15) begin
          p_hend = 33'd16 + {1'b0, p_word};
          if (p_word == 0) field_done(o);
          else p_ph = PH_CODE;
        end
      end
      PH_PAD8: if (o + 1 == p_seg) p_ph = PH_CODE;
      PH_CODE: begin
        p_code = b;
        if (o + 1 >= {1'b0, p_hend}) raise_error(E_OVERRUN);
        else p_ph = PH_SIGLEN;
      end
      PH_SIGLEN, PH_GLEN: begin
        if (o + 2 + b > {1'b0, p_hend}) raise_error(E_OVERRUN);
        else begin
          p_seg = o + 2 + b;
          p_ph = (p_ph == PH_SIGLEN) ? PH_SIGFIRST : PH_GBYTES;
        end
      end
      PH_SIGFIRST: begin
        if (o + 1 == p_seg) begin
          p_sig = '0;
          sig_done(o);
        end else begin
          p_sig = b;
          p_ph = PH_SIGREST;
        end
      end
      PH_SIGREST: if (o + 1 == p_seg) sig_done(o);
      PH_PAD4: if (o + 1 == p_seg) p_ph = PH_WORD;
      PH_WORD: begin
        shift_in(b);
        if (o[1:0] == 2'd3) begin
          if (p_sig == CH_U || p_sig == CH_I) begin
            if (p_code == CODE_REPLY) p_reply = p_word;
            field_done(o);
          end else if (o + 2 + {2'b0, p_word} > {1'b0, p_hend}) raise_error(E_OVERRUN);
          else begin
            p_seg = o + 2 + {2'b0, p_word};
            p_cnt = 0;
            p_ph = PH_STR;
          end
        end
      end
      PH_STR: begin
        id = (p_code == CODE_DEST) ? 0 : (p_code == CODE_MEMB) ? 1 :
             (p_code == CODE_IFACE) ? 2 : -1;
        if (o + 1 == p_seg) begin
          if (id >= 0) begin
            r = '0;
            r.kind = K_STR_END;
            r.field_id = 2'(id);
            r.char_index = 6'(p_cnt);
            expected_results.push_back(r);
          end
          field_done(o);
        end else if (id >= 0 && p_cnt < STR_MAX - 1) begin
          r = '0;
          r.kind = K_CHAR;
          r.field_id = 2'(id);
          r.char_index = 6'(p_cnt);
          r.char_value = b;
          expected_results.push_back(r);
          p_cnt++;
        end
      end
      PH_GBYTES: if (o + 1 == p_seg) field_done(o);
      PH_BODY: check_done(o);
      default: p_ph = PH_DONE;
    endcase
    p_off = o + 34'd1;
  endtask

  task automatic report(string what, res_t got, res_t exp);
    errors++;
    $display("mismatch %s: got %h exp %h", what, got, exp);
  endtask

  // driver
  int gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_valid <= 1'b0;
    end else if (pending_bytes.size() > 0) begin
      in_item <= pending_bytes.pop_front();
      in_valid <= 1'b1;
      gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_byte(in_item);
      n_sent++;
    end
  end

  // monitor
  int ostall = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (expected_results.size() == 0) begin
        report("unexpected", out_item, '0);
      end else if (out_item != expected_results[0]) begin
        report("fields", out_item, expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (ostall > 0) begin
      ostall <= ostall - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 4) == 0) ostall <= $urandom_range(0, 18);
    end
  end

  task automatic add(logic [7:0] b, bit rs = 0, bit eod = 0);
    in_item_t it;
    it.data_byte = b;
    it.restart = rs;
    it.end_of_data = eod;
    pending_bytes.push_back(it);
  endtask

  task automatic add_word(logic [31:0] w, bit big);
    for (int i = 0; i < 4; i++) add(big ? w[31 - 8 * i -: 8] : w[8 * i +: 8]);
  endtask

  // builds a message; fields appended into hdr before calling
  task automatic add_message(bit big, logic [7:0] hdr[$], logic [31:0] blen,
                             logic [7:0] typ, logic [7:0] flg, logic [31:0] ser);
    int pad;
    add(big ? CH_BIG : CH_LITTLE, 1'b1);
    add(typ); add(flg); add(8'd1);
    add_word(blen, big);
    add_word(ser, big);
    add_word(32'(hdr.size()), big);
    foreach (hdr[i]) add(hdr[i]);
    pad = (8 - (hdr.size() % 8)) % 8;
    for (int i = 0; i < pad + int'(blen); i++) add(8'($urandom));
  endtask

  // one header field at 8-aligned position within hdr
  task automatic put_field(ref logic [7:0] hdr[$], input logic [7:0] code,
                           logic [7:0] sig, int slen, bit big);
    logic [31:0] v;
    while (hdr.size() % 8) hdr.push_back(8'd0);
    hdr.push_back(code);
    hdr.push_back(8'd1);
    hdr.push_back(sig);
    hdr.push_back(8'd0);
    if (sig == CH_G) begin
      hdr.push_back(8'(slen));
      for (int i = 0; i < slen; i++) hdr.push_back(8'($urandom_range(97, 122)));
      hdr.push_back(8'd0);
    end else begin
      v = (sig == CH_U || sig == CH_I) ? $urandom : 32'(slen);
      for (int i = 0; i < 4; i++) hdr.push_back(big ? v[31 - 8 * i -: 8] : v[8 * i +: 8]);
      if (sig == CH_S || sig == CH_O) begin
        for (int i = 0; i < slen; i++) hdr.push_back(8'($urandom));
        hdr.push_back(8'd0);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0] hdr[$];
    parser_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // empty field array, bytes after completion
    hdr = {};
    add_message(1'b0, hdr, 32'd0, 8'hff, 8'h00, 32'hffffffff);
    add(8'hff); add(8'd0, 0, 1);
    // every signature, a cut destination string, repeated reply serial
    hdr = {};
    put_field(hdr, CODE_DEST, CH_S, 64, 1);
    put_field(hdr, CODE_REPLY, CH_U, 0, 1);
    put_field(hdr, CODE_MEMB, CH_O, 0, 1);
    put_field(hdr, CODE_IFACE, CH_G, 2, 1);
    put_field(hdr, CODE_REPLY, CH_I, 0, 1);
    add_message(1'b1, hdr, 32'd2, 8'h00, 8'hff, 32'h0);
    // sender waits for every pending result
    wait_idle();
    // bad endian mark, unknown signature, early end of data
    add(8'h58, 1'b1); add(8'h00);
    hdr = {8'd1, 8'd1, 8'h78, 8'd0};
    add_message(1'b0, hdr, 32'd0, 8'd1, 8'd0, 32'd1);
    add(CH_LITTLE, 1'b1); add(8'd1); add(8'd0, 0, 1);
    wait_idle();
    repeat (20) @(posedge clk);
    $display("sent %0d bytes, checked %0d results", n_sent, n_checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/dhfp_pkg.sv
src/dhfp_step.sv
src/dhfp_rfifo.sv
src/dbus_header_field_parser.sv
src/dhfp_checker.sv
sim/tb.sv
